/* sv/lc2k_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lc2k_pkg;
    localparam int MemWords   = 65536;
    localparam int MemAw      = (MemWords > 1) ? $clog2(MemWords) : 1;
    localparam int NumRegs    = 8;
    localparam logic [15:0] StepLimitReset = 16'd5000;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_EXEC  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_REG   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALTED  = 3'd1,
        ST_BADADDR = 3'd2,
        ST_LIMIT   = 3'd3,
        ST_ALREADY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NAND = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } op_t;

    // Classified request as it leaves the front end.
    typedef struct packed {
        req_t        kind;
        logic        addr_ok;
        logic [15:0] address;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] pc_now;
        logic [31:0] read_data;
        logic [15:0] executed_count;
    } rsp_t;

    function automatic logic addr_in_range(input logic signed [33:0] a);
        return (a >= 34'sd0) && (a < 34'(MemWords));
    endfunction
endpackage
`default_nettype wire

/* sv/lc2k_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module lc2k_front import lc2k_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_kind,
    input  wire logic [15:0] in_address,
    input  wire logic [2:0]  in_reg_index,
    input  wire logic [31:0] in_write_data,
    output logic             q_valid,
    input  wire logic        q_ready,
    output cmd_t             q_cmd
);
    // Two-entry queue of classified requests.
    cmd_t        buf_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wp_reg, rp_reg;
    cmd_t        c;
    logic        push, pop;

    always_comb begin
        c.kind       = req_t'(in_kind);
        c.addr_ok    = ({16'd0, in_address} < 32'(MemWords));
        c.address    = in_address;
        c.reg_index  = in_reg_index;
        c.write_data = in_write_data;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = buf_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wp_reg] <= c;
    end
endmodule
`default_nettype wire

/* sv/lc2k_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module lc2k_back import lc2k_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  cmd_t             q_cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rsp_t             out_rsp
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_LOAD  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    logic [31:0] mem [MemWords];
    logic [31:0] regs_reg [NumRegs];
    logic [MemAw-1:0] mem_raddr;
    logic [MemAw-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    logic        mem_we;
    logic        mem_re;
    logic [31:0] mem_rdata_reg;

    state_t      state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic        halted_reg, halted_next;
    logic [15:0] steps_reg, steps_next;
    logic [15:0] limit_reg;
    cmd_t        cmd_reg, cmd_next;
    rsp_t        rsp_reg, rsp_next;
    logic [2:0]  ld_reg_reg, ld_reg_next;
    logic        rf_we;
    logic [2:0]  rf_wa;
    logic [31:0] rf_wd;

    logic [2:0]  op, ra, rb, rd;
    logic [31:0] va, vb;
    logic signed [33:0] off, ea, br;
    logic [15:0] pc1;

    always_comb begin
        op  = mem_rdata_reg[24:22];
        ra  = mem_rdata_reg[21:19];
        rb  = mem_rdata_reg[18:16];
        rd  = mem_rdata_reg[2:0];
        va  = regs_reg[ra];
        vb  = regs_reg[rb];
        off = 34'(signed'(mem_rdata_reg[15:0]));
        ea  = 34'(signed'(va)) + off;
        br  = signed'({18'd0, pc_reg}) + 34'sd1 + off;
        pc1 = ({16'd0, pc_reg} + 32'd1 >= 32'(MemWords)) ? 16'd0 : pc_reg + 16'd1;
    end

    assign q_ready   = state_reg[0];
    assign out_valid = state_reg[4];
    assign out_rsp   = rsp_reg;

    always_comb begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        halted_next = halted_reg;
        steps_next  = steps_reg;
        cmd_next    = cmd_reg;
        rsp_next    = rsp_reg;
        ld_reg_next = ld_reg_reg;
        rf_we = 1'b0; rf_wa = rd; rf_wd = 32'd0;
        mem_we = 1'b0; mem_waddr = q_cmd.address[MemAw-1:0];
        mem_wdata = q_cmd.write_data;
        mem_re = 1'b0; mem_raddr = q_cmd.address[MemAw-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    cmd_next = q_cmd;
                    rsp_next.status    = ST_OK;
                    rsp_next.read_data = 32'd0;
                    state_next = S_RESP;
                    unique case (q_cmd.kind)
                        REQ_WRITE: begin
                            if (q_cmd.addr_ok) mem_we = 1'b1;
                            else rsp_next.status = ST_BADADDR;
                        end
                        REQ_READ: begin
                            if (q_cmd.addr_ok) begin
                                mem_re = 1'b1;
                                state_next = S_LOAD;
                            end else rsp_next.status = ST_BADADDR;
                        end
                        REQ_REG: rsp_next.read_data = regs_reg[q_cmd.reg_index];
                        REQ_EXEC: begin
                            if (halted_reg) rsp_next.status = ST_ALREADY;
                            else if (steps_reg >= limit_reg) rsp_next.status = ST_LIMIT;
                            else begin
                                mem_re = 1'b1;
                                mem_raddr = pc_reg[MemAw-1:0];
                                state_next = S_EXEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
                rsp_next.status = (op == OP_HALT) ? ST_HALTED : ST_OK;
                unique case (op_t'(op))
                    OP_ADD: begin
                        rf_we = 1'b1; rf_wd = va + vb; pc_next = pc1;
                    end
                    OP_NAND: begin
                        rf_we = 1'b1; rf_wd = ~(va & vb); pc_next = pc1;
                    end
                    OP_LW: begin
                        if (addr_in_range(ea)) begin
                            mem_re = 1'b1; mem_raddr = ea[MemAw-1:0];
                            ld_reg_next = rb; pc_next = pc1;
                            state_next = S_LOAD;
                        end else rsp_next.status = ST_BADADDR;
                    end
                    OP_SW: begin
                        if (addr_in_range(ea)) begin
                            mem_we = 1'b1; mem_waddr = ea[MemAw-1:0];
                            mem_wdata = vb; pc_next = pc1;
                        end else rsp_next.status = ST_BADADDR;
                    end
                    OP_BEQ: begin
                        if (va != vb) pc_next = pc1;
                        else if (addr_in_range(br)) pc_next = br[15:0];
                        else rsp_next.status = ST_BADADDR;
                    end
                    OP_JALR: begin
                        if (addr_in_range(34'(signed'(va)))) begin
                            rf_we = 1'b1; rf_wa = rb;
                            rf_wd = {16'd0, pc_reg} + 32'd1;
                            pc_next = va[15:0];
                        end else rsp_next.status = ST_BADADDR;
                    end
                    OP_HALT: begin
                        halted_next = 1'b1; pc_next = pc1;
                    end
                    default: pc_next = pc1;
                endcase
                if (rsp_next.status != ST_BADADDR && steps_reg != 16'hFFFF)
                    steps_next = steps_reg + 16'd1;
            end
            S_LOAD: begin
                state_next = S_RESP;
                if (cmd_reg.kind == REQ_READ) rsp_next.read_data = mem_rdata_reg;
                else begin
                    rf_we = 1'b1; rf_wa = ld_reg_reg; rf_wd = mem_rdata_reg;
                end
            end
            S_FETCH: state_next = S_IDLE;
            S_RESP: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        rsp_next.pc_now         = pc_next;
        rsp_next.executed_count = steps_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pc_reg     <= 16'd0;
            halted_reg <= 1'b0;
            steps_reg  <= 16'd0;
            limit_reg  <= StepLimitReset;
            for (int i = 0; i < NumRegs; i++) regs_reg[i] <= 32'd0;
        end else begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            halted_reg <= halted_next;
            steps_reg  <= steps_next;
            if (cfg_we) limit_reg <= cfg_wdata;
            if (rf_we) regs_reg[rf_wa] <= rf_wd;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        rsp_reg    <= rsp_next;
        ld_reg_reg <= ld_reg_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_rdata_reg <= mem[mem_raddr];
    end
endmodule
`default_nettype wire

/* sv/lc2k_instruction_executor_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// LC2K executor: an eight-register, word-addressed core with a private
// 64K-word memory. Each input item is one request (load a word, execute one
// instruction, read a word, read a register) and yields exactly one result
// item carrying status, pc, read data and the executed-instruction count.
// A front end classifies requests into a two-entry queue; the back end
// services one at a time. Register reads, memory writes, rejected memory
// requests and execute requests refused (core halted or at its step limit)
// go from idle straight to the response state. Memory reads and executed
// instructions pass through a load or execute state, an in-range LW through
// both, as fetch and data share the single memory port. Memory words must be
// written before being read. The user must write step_limit through
// cfg_we/cfg_wdata only while the block is idle; the block never checks this.
module lc2k_instruction_executor_unit import lc2k_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tuser: req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    // tdata: address[15:0], reg_index[18:16], write_data[50:19], zero fill
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: status[2:0], pc_now[18:3], read_data[50:19], executed_count[66:51]
    output logic [71:0]      m_tdata
);
    logic q_valid, q_ready;
    cmd_t q_cmd;
    rsp_t rsp;

    lc2k_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_kind(s_tuser),
        .in_address(s_tdata[15:0]), .in_reg_index(s_tdata[18:16]),
        .in_write_data(s_tdata[50:19]),
        .q_valid, .q_ready, .q_cmd
    );

    lc2k_back u_back (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .q_valid, .q_ready, .q_cmd,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_rsp(rsp)
    );

    assign m_tdata = {5'd0, rsp.executed_count, rsp.read_data, rsp.pc_now, rsp.status};
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Shadow copy of the executor and the queue of results it still owes.
class lc2k_scoreboard;
    logic [31:0] regs [8];
    logic [31:0] mem [int];
    int          addrs[$];
    logic [15:0] pc;
    bit          halted;
    logic [15:0] steps;
    logic [15:0] limit;
    lc2k_pkg::rsp_t owed[$];
    int          errors;

    function new();
        foreach (regs[i]) regs[i] = '0;
        pc     = '0;
        halted = 0;
        steps  = '0;
        limit  = lc2k_pkg::StepLimitReset;
        errors = 0;
    endfunction

    function void put_word(int a, logic [31:0] d);
        if (!mem.exists(a)) addrs.push_back(a);
        mem[a] = d;
    endfunction

    // One instruction at the current pc; returns the status it answers.
    function lc2k_pkg::status_t run_instr();
        logic [31:0]     ins;
        lc2k_pkg::op_t   op;
        logic [2:0]      ra, rb, rd;
        longint          off, ea;
        if (halted) return lc2k_pkg::ST_ALREADY;
        if (steps >= limit) return lc2k_pkg::ST_LIMIT;
        ins = mem[int'(pc)];
        op  = lc2k_pkg::op_t'(ins[24:22]);
        ra  = ins[21:19];
        rb  = ins[18:16];
        rd  = ins[2:0];
        off = longint'($signed(ins[15:0]));
        case (op)
            lc2k_pkg::OP_ADD: begin
                regs[rd] = regs[ra] + regs[rb];
                pc = pc + 16'd1;
            end
            lc2k_pkg::OP_NAND: begin
                regs[rd] = ~(regs[ra] & regs[rb]);
                pc = pc + 16'd1;
            end
            lc2k_pkg::OP_LW: begin
                ea = longint'($signed(regs[ra])) + off;
                if (ea < 0 || ea > 65535) return lc2k_pkg::ST_BADADDR;
                regs[rb] = mem[int'(ea)];
                pc = pc + 16'd1;
            end
            lc2k_pkg::OP_SW: begin
                ea = longint'($signed(regs[ra])) + off;
                if (ea < 0 || ea > 65535) return lc2k_pkg::ST_BADADDR;
                put_word(int'(ea), regs[rb]);
                pc = pc + 16'd1;
            end
            lc2k_pkg::OP_BEQ: begin
                if (regs[ra] == regs[rb]) begin
                    ea = longint'(pc) + 1 + off;
                    if (ea < 0 || ea > 65535) return lc2k_pkg::ST_BADADDR;
                    pc = ea[15:0];
                end else begin
                    pc = pc + 16'd1;
                end
            end
            lc2k_pkg::OP_JALR: begin
                // The target is taken before regB is written, so ra == rb works.
                ea = longint'($signed(regs[ra]));
                if (ea < 0 || ea > 65535) return lc2k_pkg::ST_BADADDR;
                regs[rb] = {16'd0, pc} + 32'd1;
                pc = ea[15:0];
            end
            lc2k_pkg::OP_HALT: begin
                halted = 1;
                pc = pc + 16'd1;
            end
            default: pc = pc + 16'd1;
        endcase
        if (steps != 16'hFFFF) steps = steps + 16'd1;
        return (op == lc2k_pkg::OP_HALT) ? lc2k_pkg::ST_HALTED : lc2k_pkg::ST_OK;
    endfunction

    function void note_request(lc2k_pkg::req_t kind, logic [15:0] a, logic [2:0] ri,
                               logic [31:0] wd);
        lc2k_pkg::rsp_t r;
        r.status    = lc2k_pkg::ST_OK;
        r.read_data = '0;
        case (kind)
            lc2k_pkg::REQ_WRITE: put_word(int'(a), wd);
            lc2k_pkg::REQ_EXEC:  r.status = run_instr();
            lc2k_pkg::REQ_READ:  r.read_data = mem[int'(a)];
            default:             r.read_data = regs[ri];
        endcase
        r.pc_now         = pc;
        r.executed_count = steps;
        owed.push_back(r);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic [71:0] d);
        lc2k_pkg::rsp_t e;
        if (owed.size() == 0) begin
            report($sformatf("unexpected result item %h", d));
            return;
        end
        e = owed.pop_front();
        if (d[2:0] != e.status)
            report($sformatf("status %0d, expected %0d", d[2:0], e.status));
        if (d[18:3] != e.pc_now)
            report($sformatf("pc_now %h, expected %h", d[18:3], e.pc_now));
        if (d[50:19] != e.read_data)
            report($sformatf("read_data %h, expected %h", d[50:19], e.read_data));
        if (d[66:51] != e.executed_count)
            report($sformatf("executed_count %h, expected %h", d[66:51], e.executed_count));
    endtask
endclass

module tb_top;
    import lc2k_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;

    lc2k_scoreboard sb = new();

    // Idle percentages per phase and the long receiver hold-off counter.
    int src_idle = 0;
    int snk_stall = 0;
    int hold_cnt = 0;
    int quiet = 0;
    localparam int WatchdogLimit = 4000;

    lc2k_instruction_executor_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // The receiver either honors a requested hold-off or stalls at random.
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            m_tready = 0;
            hold_cnt--;
        end else begin
            m_tready = ($urandom_range(99) >= snk_stall);
        end
    end

    // Result checking and the watchdog, both sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WatchdogLimit) begin
                $display("Watchdog expired at %0t", $realtime);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one item, wait for its handshake, then update the shadow model.
    task send(req_t kind, logic [15:0] a, logic [2:0] ri, logic [31:0] wd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle) gap++;
        if (gap > 0) begin
            @(negedge aclk) s_tvalid = 0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1;
        s_tuser  = kind;
        s_tdata  = {5'd0, wd, ri, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, a, ri, wd);
    endtask

    // Stop offering items until every owed result has come back.
    task drain();
        @(negedge aclk) s_tvalid = 0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task set_limit(logic [15:0] v);
        drain();
        @(negedge aclk);
        cfg_we    = 1;
        cfg_wdata = v;
        @(negedge aclk) cfg_we = 0;
        sb.limit = v;
    endtask

    function automatic logic [31:0] enc(op_t op, logic [2:0] ra, logic [2:0] rb,
                                        logic [15:0] low);
        return {7'd0, op, ra, rb, low};
    endfunction

    // Random instruction; memory offsets mostly aim at a valid address.
    function automatic logic [31:0] rand_instr();
        int          r;
        op_t         op;
        logic [2:0]  ra, rb;
        logic [15:0] low;
        longint      tgt, offl;
        r   = $urandom_range(99);
        op  = (r < 15) ? OP_ADD : (r < 30) ? OP_NAND : (r < 50) ? OP_LW :
              (r < 65) ? OP_SW : (r < 80) ? OP_BEQ : (r < 88) ? OP_JALR : OP_NOOP;
        ra  = $urandom_range(7);
        rb  = $urandom_range(7);
        low = $urandom;
        if ((op == OP_LW || op == OP_SW) && $urandom_range(99) < 85) begin
            tgt  = ($urandom_range(9) < 8) ? $urandom_range(511) : $urandom_range(65535);
            offl = tgt - longint'($signed(sb.regs[ra]));
            if (offl >= -32768 && offl <= 32767) low = offl[15:0];
        end else if (op == OP_BEQ && $urandom_range(99) < 80) begin
            low = 16'($signed($urandom_range(12)) - 6);
        end
        return {7'($urandom), op, ra, rb, low};
    endfunction

    // Execute one instruction, first making sure the fetch and any load
    // touch only words that were written.
    task exec_step();
        logic [31:0] ins;
        longint      ea;
        if (!sb.halted && sb.steps < sb.limit) begin
            if (!sb.mem.exists(int'(sb.pc)) || $urandom_range(99) < 30)
                send(REQ_WRITE, sb.pc, $urandom, rand_instr());
            ins = sb.mem[int'(sb.pc)];
            if (ins[24:22] == OP_LW) begin
                ea = longint'($signed(sb.regs[ins[21:19]])) + longint'($signed(ins[15:0]));
                if (ea >= 0 && ea <= 65535 && !sb.mem.exists(int'(ea)))
                    send(REQ_WRITE, ea[15:0], $urandom, $urandom);
            end
        end
        send(REQ_EXEC, $urandom, $urandom, $urandom);
    endtask

    task exec_at(logic [31:0] ins);
        send(REQ_WRITE, sb.pc, 3'd0, ins);
        send(REQ_EXEC, 16'd0, 3'd0, 32'd0);
    endtask

    task rand_item();
        int r;
        r = $urandom_range(99);
        if (r < 60) exec_step();
        else if (r < 75) send(REQ_WRITE, $urandom, $urandom, $urandom);
        else if (r < 88)
            send(REQ_READ, sb.addrs[$urandom_range(sb.addrs.size() - 1)], $urandom, $urandom);
        else send(REQ_REG, $urandom, $urandom, $urandom);
    endtask

    task run_phase(int n, int idle, int stall);
        src_idle  = idle;
        snk_stall = stall;
        repeat (n) rand_item();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn = 1;

        // Directed part: field extremes and each corner of the instruction set.
        send(REQ_WRITE, 16'hFFFF, 3'd7, 32'h7FFF_FFFF);
        send(REQ_WRITE, 16'd200, 3'd0, 32'h8000_0000);
        send(REQ_READ, 16'd200, 3'd0, 32'd0);
        send(REQ_READ, 16'hFFFF, 3'd0, 32'd0);
        send(REQ_REG, 16'd0, 3'd7, 32'd0);
        send(REQ_WRITE, 16'd100, 3'd0, 32'd65535);
        exec_at(enc(OP_LW, 3'd0, 3'd1, 16'd100));
        exec_at(enc(OP_NAND, 3'd0, 3'd0, 16'd3));
        exec_at(enc(OP_ADD, 3'd1, 3'd3, 16'd4));
        // A load one below address zero is rejected and pc stays put.
        exec_at(enc(OP_LW, 3'd3, 3'd5, 16'd0));
        exec_at(enc(OP_SW, 3'd0, 3'd4, 16'd300));
        // A taken branch far below zero is rejected.
        exec_at(enc(OP_BEQ, 3'd0, 3'd0, 16'h8000));
        exec_at(enc(OP_BEQ, 3'd1, 3'd0, 16'h7FFF));
        // A jump to a negative register value is rejected.
        exec_at(enc(OP_JALR, 3'd3, 3'd6, 16'd0));
        // Jump to the last word, whose no-op wraps pc back to zero.
        exec_at(enc(OP_JALR, 3'd1, 3'd2, 16'd0));
        exec_at(enc(OP_NOOP, 3'd7, 3'd7, 16'hFFFF));
        // Same register as target and link.
        exec_at(enc(OP_JALR, 3'd2, 3'd2, 16'd0));
        send(REQ_READ, 16'd300, 3'd0, 32'hFFFF_FFFF);
        send(REQ_REG, 16'hFFFF, 3'd2, 32'd0);

        // Random part in several idle settings and step limits.
        run_phase(90, 0, 0);
        set_limit(16'(sb.steps + 5));
        hold_cnt = 300;
        run_phase(65, 82, 0);
        set_limit(16'hFFFF);
        run_phase(90, 0, 82);
        drain();
        set_limit(16'd1);
        run_phase(35, 26, 26);
        set_limit(16'hFFFF);
        run_phase(100, 26, 26);

        // Halt is final, so it closes the run.
        exec_at(enc(OP_HALT, 3'd0, 3'd0, 16'd0));
        send(REQ_EXEC, 16'd0, 3'd0, 32'd0);
        send(REQ_REG, 16'd0, 3'd2, 32'd0);

        drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* lc2k_instruction_executor_unit.f */
sv/lc2k_pkg.sv
sv/lc2k_front.sv
sv/lc2k_back.sv
sv/lc2k_instruction_executor_unit.sv
tb/tb_top.sv
